@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion helpers, clocked on the rising edge and held off while reset is low.
`ifndef ASSERT_OFF
`define ASSERT_AR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_AR(lbl, clk, rstn, !(expr), msg)
`else
`define ASSERT_AR(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ design/rapq_pkg.sv @@
package rapq_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 11;
  localparam int AMT_W     = 32;
  localparam int WORD_W    = 64;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 64;

  localparam int DEFAULT_DEPTH = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;    // write zero at the sweep address
    logic load;      // capture a new request
    logic upd_rd;    // read one word of an update range
    logic pt_rd;     // read the word of a point query
    logic out_load;  // move read data into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd_empty; // clamped range of the offered request is empty
    logic at_end;    // sweep address sits on the last word of the range
    logic clr_done;  // sweep address sits on the last word of the store
  } sts_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ design/rapq_ram.sv @@
module rapq_ram #(
  parameter int WIDTH = rapq_pkg::WORD_W,
  parameter int DEPTH = rapq_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [rapq_pkg::addr_w(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [rapq_pkg::addr_w(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rapq_dp.sv @@
module rapq_dp #(
  parameter int DEPTH = rapq_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rapq_pkg::cmd_t                    cmd_i,
  output rapq_pkg::sts_t                    sts_o,
  input  rapq_pkg::op_e                     op_i,
  input  logic [rapq_pkg::IDX_W-1:0]        range_start_i,
  input  logic [rapq_pkg::IDX_W-1:0]        range_end_i,
  input  logic signed [rapq_pkg::AMT_W-1:0] amount_i,
  input  logic [rapq_pkg::IDX_W-1:0]        read_index_i,
  output logic signed [rapq_pkg::WORD_W-1:0] read_value_o
);

  localparam int AW = rapq_pkg::addr_w(DEPTH);
  localparam int CW = ((rapq_pkg::IDX_W > AW) ? rapq_pkg::IDX_W : AW) + 1;
  localparam int WW = rapq_pkg::WORD_W;
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] last_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_vld_q;
  logic          rd_oob_q;
  logic [WW-1:0] delta_q;
  logic [WW-1:0] out_q;

  logic [CW-1:0] first_x, last_x, idx_x, first_c, last_c;
  logic [CW-1:0] first_m1, last_m1, idx_m1;
  logic [WW-1:0] amt_x;
  logic          idx_oob;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  // Clamp the range to the store: a start of zero acts as one, an end past the store as DEPTH.
  always_comb begin
    first_x  = {{(CW-rapq_pkg::IDX_W){1'b0}}, range_start_i};
    last_x   = {{(CW-rapq_pkg::IDX_W){1'b0}}, range_end_i};
    idx_x    = {{(CW-rapq_pkg::IDX_W){1'b0}}, read_index_i};
    first_c  = (first_x == '0) ? CW'(1) : first_x;
    last_c   = (last_x > DepthC) ? DepthC : last_x;
    first_m1 = first_c - CW'(1);
    last_m1  = last_c - CW'(1);
    idx_m1   = idx_x - CW'(1);
    idx_oob  = (idx_x == '0) || (idx_x > DepthC);
    amt_x    = {{(WW-rapq_pkg::AMT_W){amount_i[rapq_pkg::AMT_W-1]}}, amount_i};
  end

  assign sts_o.upd_empty = first_c > last_c;
  assign sts_o.at_end    = addr_q == last_q;
  assign sts_o.clr_done  = addr_q == LastAddr;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = (op_i == rapq_pkg::OP_READ) ? idx_m1[AW-1:0] : first_m1[AW-1:0];
    end else if (cmd_i.clr_wr || cmd_i.upd_rd) begin
      addr_d = addr_q + AW'(1);
    end
  end

  // The sweep address also drives the clearing pass, so it is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      wr_vld_q <= cmd_i.upd_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q   <= last_m1[AW-1:0];
      rd_oob_q <= idx_oob;
      delta_q  <= (op_i == rapq_pkg::OP_SUB) ? (WW'(0) - amt_x) : amt_x;
    end
    if (cmd_i.upd_rd) begin
      wr_addr_q <= addr_q;
    end
    if (cmd_i.out_load) begin
      out_q <= rd_oob_q ? '0 : ram_rdata;
    end
  end

  // Write stage of the read-modify-write runs one word behind the read.
  always_comb begin
    ram_we    = cmd_i.clr_wr || wr_vld_q;
    ram_waddr = cmd_i.clr_wr ? addr_q : wr_addr_q;
    ram_wdata = cmd_i.clr_wr ? '0 : (ram_rdata + delta_q);
  end

  rapq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.upd_rd || cmd_i.pt_rd),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign read_value_o = out_q;

endmodule

@@ design/rapq_ctrl.sv @@
module rapq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rapq_pkg::op_e  op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rapq_pkg::sts_t sts_i,
  output rapq_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_UPD    = 6'b000100,
    ST_UPD_WB = 6'b001000,
    ST_RD     = 6'b010000,
    ST_RD_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (op_i) inside
            rapq_pkg::OP_ADD, rapq_pkg::OP_SUB: begin
              state_d = sts_i.upd_empty ? ST_IDLE : ST_UPD;
            end
            rapq_pkg::OP_READ: state_d = ST_RD;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_UPD: begin
        cmd_o.upd_rd = 1'b1;
        if (sts_i.at_end) begin
          state_d = ST_UPD_WB;
        end
      end
      ST_UPD_WB: state_d = ST_IDLE;
      ST_RD: begin
        cmd_o.pt_rd = 1'b1;
        state_d     = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ design/range_add_point_query_memory_unit.sv @@
// An add or subtract over N words (after clamping) holds the input while it is accepted, reads
// the memory once per word and writes the last word back, set by the single read and single
// write port of the word memory; an empty range or the unused code ends on acceptance.
// A read holds the input through a memory lookup and then the load of the output register; it
// holds longer while an older result still waits. Reset clears all control state at once, then a pass
// writes zero into every word, one per cycle, while s_tready_o stays low.
`include "assert_macros.svh"

module range_add_point_query_memory_unit #(
  parameter int DEPTH = rapq_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request stream.
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // [1:0] operation, [12:2] range_start, [23:13] range_end, [55:24] amount,
  // [66:56] read_index, [71:67] zero
  input  logic [rapq_pkg::S_TDATA_W-1:0]    s_tdata_i,
  // Result stream, one item per read request.
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // [63:0] read_value
  output logic [rapq_pkg::M_TDATA_W-1:0]    m_tdata_o
);

  // Unpacked request fields. The unused top bits of s_tdata_i are ignored.
  rapq_pkg::op_e                      op;
  logic [rapq_pkg::IDX_W-1:0]         range_start;
  logic [rapq_pkg::IDX_W-1:0]         range_end;
  logic signed [rapq_pkg::AMT_W-1:0]  amount;
  logic [rapq_pkg::IDX_W-1:0]         read_index;
  logic signed [rapq_pkg::WORD_W-1:0] read_value;

  rapq_pkg::cmd_t cmd;
  rapq_pkg::sts_t sts;

  assign op          = rapq_pkg::op_e'(s_tdata_i[1:0]);
  assign range_start = s_tdata_i[12:2];
  assign range_end   = s_tdata_i[23:13];
  assign amount      = s_tdata_i[55:24];
  assign read_index  = s_tdata_i[66:56];

  // The controller sequences the clearing pass, the per-word read-modify-write of an update and
  // the point read; it owns both handshakes, including the output register's valid flag, so a
  // new request is taken while a result still waits downstream.
  rapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .op_i        (op),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the word memory, the sweep address, the signed delta (already negated
  // for a subtract) and the output register.
  rapq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op),
    .range_start_i (range_start),
    .range_end_i   (range_end),
    .amount_i      (amount),
    .read_index_i  (read_index),
    .read_value_o  (read_value)
  );

  assign m_tdata_o = read_value;

  // No request may be taken while the clearing pass is still writing zeros.
  `ASSERT_NEVER(a_no_accept_in_clear, clk_i, rst_ni, cmd.clr_wr && s_tready_o, "request taken during clear")

  // A new result is only loaded when the output register is empty or being drained.
  `ASSERT_AR(a_no_result_overwrite, clk_i, rst_ni, cmd.out_load |-> (!m_tvalid_o || m_tready_i), "pending result overwritten")

  // An accepted read looks up the memory in the next cycle.
  `ASSERT_AR(a_read_lookup, clk_i, rst_ni, (s_tvalid_i && s_tready_o && op == rapq_pkg::OP_READ) |=> cmd.pt_rd, "read lookup missing")

  // The controller never issues more than one of the clear, update-read and point-read commands at once.
  `ASSERT_AR(a_single_access, clk_i, rst_ni, $onehot0({cmd.clr_wr, cmd.upd_rd, cmd.pt_rd}), "conflicting memory commands")

endmodule
